/* hdl/brle_pkg.sv */
// Package for the byte run-length encoder: payload structs, sequencer states
// and token constants. Has no dependencies of its own.
package brle_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } enc_in_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic [3:0]  byte_count;
    logic        pass_end;
  } enc_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_APPEND,
    S_CAPCHK,
    S_NEWRUN,
    S_LAST,
    S_TAIL,
    S_TERM,
    S_LIT_HDR,
    S_LIT_BODY,
    S_RUN_HDR,
    S_RUN_BYTE
  } seq_state_e;

  localparam logic [7:0] RUN_FLAG  = 8'h80;
  localparam logic [7:0] TERM_BYTE = 8'h00;
  localparam int unsigned MIN_RUN  = 3;
  localparam logic [2:0] LAST_SLOT = 3'd7;

endpackage

/* hdl/byte_rle_encoder.sv */
// Byte run-length encoder top level: sequencer, literal byte store and
// output word packer. Depends on brle_pkg.
//
//  port group   dir  handshake               payload
//  in_*         in   in_valid_i / in_stall_o  enc_in_t  (data_byte, last_byte)
//  out_*        out  out_valid_o / out_stall_i enc_out_t (out_word, byte_count, pass_end)
//
// An item passes through the decide state, then the capacity check when it
// extends a run or the new-run state when it starts one (after the append
// state when short bytes join the literal first), then the last-byte check.
// Each coded byte (token headers, run bytes, literal bytes read back from the
// literal store, the terminator) and each literal store append takes a step;
// the last byte of a pass with a literal pending also passes the tail state.
// The single sequencer moves one byte a cycle through the packer unless stalled.
// Reset clears all control state; the literal store needs no clearing pass,
// as only entries already written are read back.
// A stalled output holds the sequencer only when a packed word must leave.
module byte_rle_encoder
  import brle_pkg::*;
#(
  parameter int unsigned MAX_RUN = 127
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  enc_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output enc_out_t out_data_o
);

  localparam int unsigned CNT_W = $clog2(MAX_RUN + 1);
  localparam int unsigned IDX_W = $clog2(MAX_RUN);

  // Sequencer state and the item being worked on.
  seq_state_e state_q, state_d;
  seq_state_e ret_q, ret_d;
  logic [7:0] x_q;
  logic       last_q;

  // Encoder state.
  logic [CNT_W-1:0] lit_count_q, lit_count_d;
  logic [CNT_W-1:0] run_len_q, run_len_d;
  logic [7:0]       run_byte_q, run_byte_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;

  // Literal store: one write port for appends, one registered read port.
  logic [7:0]       lit_mem [MAX_RUN];
  logic             mem_we;
  logic [7:0]       rd_data_q;

  // Packer.
  logic [63:0] pack_q, pack_d;
  logic [2:0]  fill_q, fill_d;
  logic        put_valid;
  logic [7:0]  put_byte;
  logic        put_end;
  logic        will_emit;
  logic        put_ok;
  logic        put_go;
  logic [63:0] merged;
  logic        out_valid_q, out_valid_d;
  enc_out_t    out_q, out_d;

  logic accept;
  logic match;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign match = (run_len_q != '0) && (x_q == run_byte_q);

  // A byte that completes a word may only move when the output register
  // is free or empties in this cycle.
  assign will_emit = put_end || (fill_q == LAST_SLOT);
  assign put_ok    = !will_emit || !out_valid_q || !out_stall_i;
  assign put_go    = put_valid && put_ok;
  assign merged    = pack_q | (64'(put_byte) << {fill_q, 3'b000});

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    lit_count_d = lit_count_q;
    run_len_d   = run_len_q;
    run_byte_d  = run_byte_q;
    rd_idx_d    = rd_idx_q;
    mem_we      = 1'b0;
    put_valid   = 1'b0;
    put_byte    = TERM_BYTE;
    put_end     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (match) begin
          run_len_d = run_len_q + 1'b1;
          if ((lit_count_q != '0) && (run_len_q + 1'b1 == CNT_W'(MIN_RUN))) begin
            ret_d   = S_CAPCHK;
            state_d = S_LIT_HDR;
          end else begin
            state_d = S_CAPCHK;
          end
        end else if (run_len_q >= CNT_W'(MIN_RUN)) begin
          ret_d   = S_NEWRUN;
          state_d = S_RUN_HDR;
        end else begin
          state_d = S_APPEND;
        end
      end
      S_APPEND: begin
        // Short runs of one or two bytes join the literal.
        if (run_len_q == '0) begin
          state_d = S_NEWRUN;
        end else begin
          mem_we      = 1'b1;
          lit_count_d = lit_count_q + 1'b1;
          run_len_d   = run_len_q - 1'b1;
          if (lit_count_q == CNT_W'(MAX_RUN - 1)) begin
            ret_d   = S_APPEND;
            state_d = S_LIT_HDR;
          end
        end
      end
      S_CAPCHK: begin
        if ((lit_count_q == '0) && (run_len_q >= CNT_W'(MAX_RUN))) begin
          ret_d   = S_LAST;
          state_d = S_RUN_HDR;
        end else begin
          state_d = S_LAST;
        end
      end
      S_NEWRUN: begin
        run_byte_d = x_q;
        run_len_d  = CNT_W'(1);
        state_d    = S_LAST;
      end
      S_LAST: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (lit_count_q != '0) begin
          state_d = S_TAIL;
        end else if (run_len_q != '0) begin
          ret_d   = S_TERM;
          state_d = S_RUN_HDR;
        end else begin
          state_d = S_TERM;
        end
      end
      S_TAIL: begin
        // End of pass: tail bytes top up the pending literal.
        if ((run_len_q != '0) && (lit_count_q != '0)) begin
          mem_we      = 1'b1;
          lit_count_d = lit_count_q + 1'b1;
          run_len_d   = run_len_q - 1'b1;
          if (lit_count_q == CNT_W'(MAX_RUN - 1)) begin
            ret_d   = S_TAIL;
            state_d = S_LIT_HDR;
          end
        end else if (lit_count_q != '0) begin
          ret_d   = S_LAST;
          state_d = S_LIT_HDR;
        end else begin
          state_d = S_LAST;
        end
      end
      S_TERM: begin
        put_valid = 1'b1;
        put_byte  = TERM_BYTE;
        put_end   = 1'b1;
        if (put_ok) begin
          run_len_d = '0;
          state_d   = S_IDLE;
        end
      end
      S_LIT_HDR: begin
        put_valid = 1'b1;
        put_byte  = 8'(lit_count_q);
        if (put_ok) begin
          state_d = S_LIT_BODY;
        end
      end
      S_LIT_BODY: begin
        put_valid = 1'b1;
        put_byte  = rd_data_q;
        if (put_ok) begin
          if (CNT_W'(rd_idx_q) + 1'b1 == lit_count_q) begin
            rd_idx_d    = '0;
            lit_count_d = '0;
            state_d     = ret_q;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
      end
      S_RUN_HDR: begin
        put_valid = 1'b1;
        put_byte  = RUN_FLAG | 8'(run_len_q);
        if (put_ok) begin
          state_d = S_RUN_BYTE;
        end
      end
      S_RUN_BYTE: begin
        put_valid = 1'b1;
        put_byte  = run_byte_q;
        if (put_ok) begin
          run_len_d = '0;
          state_d   = ret_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Packer and output register.
  always_comb begin
    pack_d      = pack_q;
    fill_d      = fill_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (put_go) begin
      if (will_emit) begin
        out_d.out_word   = merged;
        out_d.byte_count = 4'(fill_q) + 4'd1;
        out_d.pass_end   = put_end;
        out_valid_d      = 1'b1;
        pack_d           = '0;
        fill_d           = '0;
      end else begin
        pack_d = merged;
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      lit_count_q <= '0;
      run_len_q   <= '0;
      run_byte_q  <= '0;
      rd_idx_q    <= '0;
      pack_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      lit_count_q <= lit_count_d;
      run_len_q   <= run_len_d;
      run_byte_q  <= run_byte_d;
      rd_idx_q    <= rd_idx_d;
      pack_q      <= pack_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      x_q    <= in_data_i.data_byte;
      last_q <= in_data_i.last_byte;
    end
  end

  // The read address follows the next read index, so the registered data
  // always matches the current index. Appends never happen while a literal
  // is being read back.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lit_mem[lit_count_q[IDX_W-1:0]] <= run_byte_q;
    end
    rd_data_q <= lit_mem[rd_idx_d];
  end

`ifndef SYNTH
  a_accept_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_DECIDE))
    else $error("accepted transfer did not start the sequencer");

  a_idle_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |->
      ((lit_count_q < CNT_W'(MAX_RUN)) && (run_len_q <= CNT_W'(MAX_RUN))))
    else $error("literal or run count out of range between items");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.byte_count != 4'd0) && (out_data_o.byte_count <= 4'd8)))
    else $error("result word carries a bad byte count");

  a_pass_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (put_go && put_end) |=> ((fill_q == '0) && (lit_count_q == '0) && (run_len_q == '0)))
    else $error("state not cleared after the end of a pass");
`endif

endmodule
